FILE: src/salts_pkg.sv
// Shared constants and types of the set-associative LRU tag store.
`default_nettype none
package salts_pkg;

   localparam int WAYS         = 4;
   localparam int SETS         = 16;
   localparam int ADDR_BITS    = 16;
   localparam int AGE_BITS     = 8;
   localparam int WAY_W        = 2;
   localparam int SET_W        = 4;
   localparam int MAX_SET_BITS = 4;
   localparam int OFFSET_W     = 4;
   localparam int SETB_W       = 3;
   localparam int CSR_DATA_W   = 4;
   localparam int CSR_ADDR_W   = 1;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_BITS = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SET_BITS    = 1'd1;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET   = 4'd4;
   localparam logic [SETB_W-1:0]   SET_BITS_RESET = 3'd4;
   localparam logic [AGE_BITS-1:0] AGE_MAX        = {AGE_BITS{1'b1}};

   typedef logic [ADDR_BITS-1:0] tag_type;
   typedef logic [AGE_BITS-1:0]  age_type;
   typedef tag_type [WAYS-1:0]   tag_row_type;
   typedef age_type [WAYS-1:0]   age_row_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

endpackage
`default_nettype wire

FILE: src/salts_ctrl.sv
// Controller: word handshakes and sequencing of read and write-back.
`default_nettype none
module salts_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output salts_pkg::cmd_type     cmd
);

   salts_pkg::state_type state_ff, state_in;
   logic                 valid_ff, valid_in;

   always_comb begin
      req_tready  = (state_ff == salts_pkg::ST_IDLE);
      cmd.capture = req_tready && req_tvalid;
      cmd.commit  = (state_ff == salts_pkg::ST_LOOKUP) && (!valid_ff || rsp_tready);
      rsp_tvalid  = valid_ff;

      state_in = state_ff;
      unique case (state_ff)
         salts_pkg::ST_IDLE: begin
            if (cmd.capture) state_in = salts_pkg::ST_LOOKUP;
         end
         salts_pkg::ST_LOOKUP: begin
            if (cmd.commit) state_in = salts_pkg::ST_IDLE;
         end
         default: state_in = salts_pkg::ST_IDLE;
      endcase

      valid_in = valid_ff;
      if (cmd.commit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= salts_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/salts_datapath.sv
// Datapath: configuration, tag and age memory, lookup and LRU update.
`default_nettype none
module salts_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire salts_pkg::cmd_type                cmd,
   input  wire logic [salts_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [salts_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [salts_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic [salts_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   logic [salts_pkg::OFFSET_W-1:0]  offset_ff;
   logic [salts_pkg::SETB_W-1:0]    set_bits_ff;

   salts_pkg::tag_row_type          tag_mem [salts_pkg::SETS];
   salts_pkg::age_row_type          age_mem [salts_pkg::SETS];
   logic [salts_pkg::WAYS-1:0]      valid_ff [salts_pkg::SETS];

   salts_pkg::tag_row_type          rd_tags_ff;
   salts_pkg::age_row_type          rd_ages_ff;
   salts_pkg::tag_type              line_ff;
   logic [salts_pkg::SET_W-1:0]     set_ff;

   salts_pkg::tag_type              line_in;
   logic [salts_pkg::SET_W-1:0]     set_in;
   logic [salts_pkg::SETB_W-1:0]    sb;
   logic [salts_pkg::SET_W-1:0]     set_mask;

   logic [salts_pkg::WAYS-1:0]      row_valid;
   logic                            hit;
   logic                            evicted;
   logic                            found;
   logic [salts_pkg::WAY_W-1:0]     way;
   salts_pkg::age_type              best;
   salts_pkg::tag_row_type          new_tags;
   salts_pkg::age_row_type          new_ages;

   logic                            hit_ff;
   logic                            evicted_ff;
   logic [salts_pkg::WAY_W-1:0]     way_ff;
   logic [salts_pkg::SET_W-1:0]     set_out_ff;

   // address split
   always_comb begin
      line_in = req_tdata >> offset_ff;
      sb = (set_bits_ff > salts_pkg::SETB_W'(salts_pkg::MAX_SET_BITS)) ?
           salts_pkg::SETB_W'(salts_pkg::MAX_SET_BITS) : set_bits_ff;
      set_mask = ~({salts_pkg::SET_W{1'b1}} << sb);
      set_in = line_in[salts_pkg::SET_W-1:0] & set_mask;
   end

   // lookup and replacement choice
   always_comb begin
      row_valid = valid_ff[set_ff];
      hit = 1'b0;
      evicted = 1'b0;
      found = 1'b0;
      way = '0;
      best = '0;
      for (int w = 0; w < salts_pkg::WAYS; w++) begin
         if (!found && row_valid[w] && rd_tags_ff[w] == line_ff) begin
            found = 1'b1;
            hit = 1'b1;
            way = salts_pkg::WAY_W'(w);
         end
      end
      for (int w = 0; w < salts_pkg::WAYS; w++) begin
         if (!found && !row_valid[w]) begin
            found = 1'b1;
            way = salts_pkg::WAY_W'(w);
         end
      end
      if (!found) begin
         evicted = 1'b1;
         for (int w = 0; w < salts_pkg::WAYS; w++) begin
            if (w == 0 || rd_ages_ff[w] > best) begin
               best = rd_ages_ff[w];
               way = salts_pkg::WAY_W'(w);
            end
         end
      end
      new_tags = rd_tags_ff;
      for (int w = 0; w < salts_pkg::WAYS; w++) begin
         if (row_valid[w] && rd_ages_ff[w] != salts_pkg::AGE_MAX) begin
            new_ages[w] = rd_ages_ff[w] + 1'b1;
         end else begin
            new_ages[w] = rd_ages_ff[w];
         end
      end
      new_ages[way] = '0;
      new_tags[way] = line_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= salts_pkg::OFFSET_RESET;
         set_bits_ff <= salts_pkg::SET_BITS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            salts_pkg::CSR_OFFSET_BITS: offset_ff <= csr_wdata[salts_pkg::OFFSET_W-1:0];
            salts_pkg::CSR_SET_BITS:    set_bits_ff <= csr_wdata[salts_pkg::SETB_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < salts_pkg::SETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else if (cmd.commit) begin
         valid_ff[set_ff][way] <= 1'b1;
      end
   end

   // row memory: read on capture, write back on commit
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         tag_mem[set_ff] <= new_tags;
         age_mem[set_ff] <= new_ages;
      end
      if (cmd.capture) begin
         rd_tags_ff <= tag_mem[set_in];
         rd_ages_ff <= age_mem[set_in];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         line_ff <= line_in;
         set_ff  <= set_in;
      end
      if (cmd.commit) begin
         hit_ff     <= hit;
         evicted_ff <= evicted;
         way_ff     <= way;
         set_out_ff <= set_ff;
      end
   end

   assign rsp_tdata = {set_out_ff, way_ff, evicted_ff, hit_ff};

endmodule
`default_nettype wire

FILE: src/set_assoc_lru_tag_store.sv
// Top level of the set-associative tag store with age-counter LRU.
//
//  channel  direction  word
//  req_     in         tdata[15:0] address
//  rsp_     out        tdata[0] hit, [1] evicted, [3:2] way_used, [7:4] set_index
//  csr_     in         index 0 offset_bits, index 1 set_bits
//
//  Each word has a registered read of the set's tag and age row, then a write
//  back of the row together with the result register load.
//  A word is taken while a result waits; it then holds in lookup until that
//  result leaves. Synchronous reset clears all valid bits at once.
`default_nettype none
module set_assoc_lru_tag_store (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [salts_pkg::REQ_DATA_W-1:0]  req_tdata,  // address
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [salts_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // hit, evicted, way_used, set_index
   input  wire logic                              csr_wr_en,
   input  wire logic [salts_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [salts_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   salts_pkg::cmd_type cmd;

   salts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   salts_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

FILE: src/salts_checker.sv
// Port checker of the tag store and its bind.
`default_nettype none
module salts_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [salts_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("hit and eviction on one word");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken during lookup");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without matching input word");

endmodule

bind set_assoc_lru_tag_store salts_checker u_salts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
